// ===== design/central_difference_edge_map_macros.svh =====
// assertion macros for the central difference edge map
// used by central_difference_edge_map.sv, no other dependencies
`ifndef CENTRAL_DIFFERENCE_EDGE_MAP_MACROS_SVH
`define CENTRAL_DIFFERENCE_EDGE_MAP_MACROS_SVH
`ifndef SYNTH
// implication checked at every rising edge outside reset
`define CDEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CDEM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CDEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CDEM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/cdem_pkg.sv =====
// types and constants of the central difference edge map
// no dependencies; used by central_difference_edge_map.sv
`timescale 1ns / 1ps

package cdem_pkg;

  localparam int unsigned IMAGE_WIDTH_W  = 11;
  localparam int unsigned IMAGE_HEIGHT_W = 16;
  localparam int unsigned THRESHOLD_W    = 17;
  localparam int unsigned CFG_DATA_W     = 17;
  localparam int unsigned CFG_INDEX_W    = 2;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_SQUARE = 2'd2;

  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST      = 11'd640;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST     = 16'd480;
  localparam logic [THRESHOLD_W-1:0]    THRESHOLD_SQUARE_RST = 17'd4064;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic edge_red;
    logic edge_green;
    logic edge_blue;
    logic frame_last;
  } out_item_t;

endpackage

// ===== design/central_difference_edge_map.sv =====
// Central difference edge map over an RGB pixel stream.
//
// Pixels enter on in_valid/in_stall/in_data in raster order; a request is
// taken at a rising edge with in_valid high and in_stall low. in_data has
// frame_start set on the first pixel of a frame, which clears the column
// and row counters. The pixel at (r,c) yields the edge flags of (r-1,c) on
// out_valid/out_stall/out_data; row 0 of a frame yields nothing, so the
// bottom row is never sent. Border results carry zero flags and frame_last
// marks the result of (height-2, width-1).
// Each result passes stage 1, stage 2 and the output register before out_valid rises.
// Throughput: one pixel per clock while out_stall is low. The middle line store is read at two
// columns and written once per pixel, the upper line store read and
// written once; that single pass per pixel sets the rate.
// A stalled result stays in the output register while up to two more
// pixels enter the pipeline; in_stall rises once all stages are full.
// Reset (rst_n low at an edge) clears the counters, the pipeline valids
// and the registers to 640 x 480 and threshold 4064. The line stores are
// not cleared; the first two rows of a frame fill them before use.
// Configuration is written over cfg_we/cfg_index/cfg_data; write it only while idle (not enforced by the block).
// Depends on cdem_pkg and central_difference_edge_map_macros.svh.
`timescale 1ns / 1ps
`include "central_difference_edge_map_macros.svh"

module central_difference_edge_map #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  cdem_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output cdem_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [cdem_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cdem_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = (AW + 1 > cdem_pkg::IMAGE_WIDTH_W) ?
                               AW + 1 : cdem_pkg::IMAGE_WIDTH_W;

  function automatic logic [15:0] diff_sq(input logic [7:0] a, input logic [7:0] b);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    p = d * d;
    return p[15:0];
  endfunction

  // configuration registers
  logic [cdem_pkg::IMAGE_WIDTH_W-1:0]  image_width_r;
  logic [cdem_pkg::IMAGE_HEIGHT_W-1:0] image_height_r;
  logic [cdem_pkg::THRESHOLD_W-1:0]    threshold_r;

  // position counters
  logic [AW-1:0]                       col_r;
  logic [cdem_pkg::IMAGE_HEIGHT_W-1:0] row_r;

  // line stores
  cdem_pkg::pix_t upper_line  [MAX_WIDTH];
  cdem_pkg::pix_t middle_line [MAX_WIDTH];

  // stage 1: store read data and pixel
  logic                 s1_valid_r;
  logic                 s1_emit_r;
  logic                 s1_inner_r;
  logic                 s1_last_r;
  logic [AW-1:0]        s1_col_r;
  cdem_pkg::pix_t       s1_px_r;
  cdem_pkg::pix_t       mid_c_r;
  cdem_pkg::pix_t       mid_r_r;
  cdem_pkg::pix_t       up_r;
  cdem_pkg::pix_t       left_r;

  // stage 2: squared differences
  logic                 s2_valid_r;
  logic                 s2_inner_r;
  logic                 s2_last_r;
  logic [15:0]          gx2_r [3];
  logic [15:0]          gy2_r [3];

  // output register
  logic                 out_valid_r;
  cdem_pkg::out_item_t  out_data_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 s2_free;
  logic                 s1_go;
  logic                 s1_free;

  logic [WW-1:0]        iw_ext;
  logic [AW-1:0]        last_col_idx;
  logic [cdem_pkg::IMAGE_HEIGHT_W-1:0] last_row_idx;
  logic [AW-1:0]        acc_c;
  logic [cdem_pkg::IMAGE_HEIGHT_W-1:0] acc_r;
  logic                 acc_last_col;
  logic                 acc_last_row;
  logic                 acc_inner;
  logic [AW-1:0]        rd_right;
  logic [AW-1:0]        col_nxt;
  logic [cdem_pkg::IMAGE_HEIGHT_W-1:0] row_nxt;
  cdem_pkg::pix_t       px;

  logic [2:0][7:0]      right_ch;
  logic [2:0][7:0]      left_ch;
  logic [2:0][7:0]      below_ch;
  logic [2:0][7:0]      up_ch;
  logic [2:0]           edge_nxt;
  logic [16:0]          sum_nxt [3];

  // pipeline flow
  assign out_free = !out_valid_r || !out_stall;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_go    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective frame size
  assign iw_ext = WW'(image_width_r);
  always_comb begin
    if (iw_ext < WW'(3)) begin
      last_col_idx = AW'(2);
    end else if (iw_ext > WW'(MAX_WIDTH)) begin
      last_col_idx = AW'(MAX_WIDTH - 1);
    end else begin
      last_col_idx = AW'(iw_ext - WW'(1));
    end
  end
  assign last_row_idx = (image_height_r < 16'd3) ? 16'd2 : image_height_r - 16'd1;

  // position of the incoming pixel
  assign acc_c        = in_data.frame_start ? '0 : col_r;
  assign acc_r        = in_data.frame_start ? '0 : row_r;
  assign acc_last_col = (acc_c >= last_col_idx);
  assign acc_last_row = (acc_r >= last_row_idx);
  assign acc_inner    = (acc_r >= 16'd2) && (acc_r <= last_row_idx) &&
                        (acc_c != '0) && (acc_c < last_col_idx);
  assign rd_right     = acc_last_col ? acc_c : acc_c + 1'b1;
  assign px           = '{red: in_data.red, green: in_data.green, blue: in_data.blue};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (acc_last_col) begin
        col_nxt = '0;
        row_nxt = acc_last_row ? '0 : acc_r + 16'd1;
      end else begin
        col_nxt = acc_c + 1'b1;
        row_nxt = acc_r;
      end
    end
  end

  // config, counters and valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= cdem_pkg::IMAGE_WIDTH_RST;
      image_height_r <= cdem_pkg::IMAGE_HEIGHT_RST;
      threshold_r    <= cdem_pkg::THRESHOLD_SQUARE_RST;
      col_r          <= '0;
      row_r          <= '0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cdem_pkg::REG_IMAGE_WIDTH:
            image_width_r <= cfg_data[cdem_pkg::IMAGE_WIDTH_W-1:0];
          cdem_pkg::REG_IMAGE_HEIGHT:
            image_height_r <= cfg_data[cdem_pkg::IMAGE_HEIGHT_W-1:0];
          cdem_pkg::REG_THRESHOLD_SQUARE:
            threshold_r <= cfg_data[cdem_pkg::THRESHOLD_W-1:0];
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (s1_free) begin
        s1_valid_r <= in_acc;
      end
      if (s2_free) begin
        s2_valid_r <= s1_go && s1_emit_r;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // middle line: center and right of the row above, written with the pixel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_c_r               <= middle_line[acc_c];
      mid_r_r               <= middle_line[rd_right];
      middle_line[acc_c]    <= px;
    end
  end

  // upper line read, forwarding a write that retires on the same edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (s1_go && (s1_col_r == acc_c)) begin
        up_r <= mid_c_r;
      end else begin
        up_r <= upper_line[acc_c];
      end
    end
  end

  // upper line write: old middle entry shifts up when stage 1 retires
  always_ff @(posedge clk) begin
    if (s1_go) begin
      upper_line[s1_col_r] <= mid_c_r;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit_r  <= (acc_r != '0);
      s1_inner_r <= acc_inner;
      s1_last_r  <= acc_last_col && acc_last_row;
      s1_col_r   <= acc_c;
      s1_px_r    <= px;
    end
    if (s1_go) begin
      left_r <= mid_c_r;
    end
  end

  assign right_ch = {mid_r_r.blue, mid_r_r.green, mid_r_r.red};
  assign left_ch  = {left_r.blue,  left_r.green,  left_r.red};
  assign below_ch = {s1_px_r.blue, s1_px_r.green, s1_px_r.red};
  assign up_ch    = {up_r.blue,    up_r.green,    up_r.red};

  // stage 2: squares per channel
  always_ff @(posedge clk) begin
    if (s1_go && s2_free) begin
      s2_inner_r <= s1_inner_r;
      s2_last_r  <= s1_last_r;
      for (int k = 0; k < 3; k++) begin
        gx2_r[k] <= diff_sq(right_ch[k], left_ch[k]);
        gy2_r[k] <= diff_sq(below_ch[k], up_ch[k]);
      end
    end
  end

  // sum of squares against the threshold
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k]  = {1'b0, gx2_r[k]} + {1'b0, gy2_r[k]};
      edge_nxt[k] = s2_inner_r && (sum_nxt[k] > threshold_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && out_free) begin
      out_data_r.edge_red   <= edge_nxt[0];
      out_data_r.edge_green <= edge_nxt[1];
      out_data_r.edge_blue  <= edge_nxt[2];
      out_data_r.frame_last <= s2_last_r;
    end
  end

  `CDEM_ASSERT_IMP(a_last_is_border, clk, rst_n, out_valid_r && out_data_r.frame_last, !out_data_r.edge_red && !out_data_r.edge_green && !out_data_r.edge_blue, "frame_last result carries an edge flag")
  `CDEM_ASSERT_IMP(a_inner_emits, clk, rst_n, s1_valid_r && s1_inner_r, s1_emit_r, "interior pixel without a result")
  `CDEM_ASSERT_NXT(a_emit_reaches_s2, clk, rst_n, s1_go && s1_emit_r, s2_valid_r, "request lost between stage 1 and stage 2")
  `CDEM_ASSERT_NXT(a_col_step, clk, rst_n, in_acc && !in_data.frame_start && !acc_last_col, col_r == AW'($past(col_r) + 1'b1), "column counter did not advance")

endmodule
